// ----- design/ort_pkg.sv -----
// ----------------------------------------------------------------------------
// ort_pkg: shared types and codes of the ordered route table
// Word layouts of the request and response channels, the operation and
// status codes, and the layout of one stored route.
// ----------------------------------------------------------------------------
package ort_pkg;

	// Operation codes of a request word. Code 3 has no meaning.
	localparam logic [1:0] OpAdd    = 2'd0;
	localparam logic [1:0] OpDel    = 2'd1;
	localparam logic [1:0] OpLookup = 2'd2;

	// Interfaces at or above this index are rejected by an add.
	localparam int unsigned PortCount = 8;

	typedef enum logic [1:0] {
		StOk        = 2'd0,
		StFull      = 2'd1,
		StBadPrefix = 2'd2,
		StNotFound  = 2'd3
	} status_t;

	typedef struct packed {
		logic [1:0]  op;
		logic [31:0] prefix_addr;
		logic [31:0] mask;
		logic [31:0] gateway;
		logic [2:0]  port;
		logic [31:0] source_addr;
		logic [31:0] dest_addr;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] next_hop;
		logic [2:0]  out_port;
		logic [31:0] out_source;
	} rsp_t;

	typedef struct packed {
		logic [31:0] prefix;
		logic [31:0] mask;
		logic [31:0] gateway;
		logic [2:0]  port;
		logic [31:0] source;
	} entry_t;

endpackage

// ----- design/ort_ifs.sv -----
// ----------------------------------------------------------------------------
// ort_ifs: request and response channels of the ordered route table
// Each channel moves one word at a clock edge where valid and ready are high.
// ----------------------------------------------------------------------------
interface ort_req_if;
	logic          valid;
	logic          ready;
	ort_pkg::req_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface ort_rsp_if;
	logic          valid;
	logic          ready;
	ort_pkg::rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- design/ort_mem.sv -----
// ----------------------------------------------------------------------------
// ort_mem: route storage
// One write port and one read port; read data is registered, so it appears
// in the cycle after the address.
// ----------------------------------------------------------------------------
module ort_mem #(
	parameter int unsigned DEPTH = 16,
	parameter int unsigned AW    = 4
) (
	input  logic                  clk,
	input  logic                  wr_en,
	input  logic [AW-1:0]         wr_addr,
	input  ort_pkg::entry_t       wr_data,
	input  logic                  rd_en,
	input  logic [AW-1:0]         rd_addr,
	output ort_pkg::entry_t       rd_data
);

	ort_pkg::entry_t mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ----- design/ordered_route_table_unit.sv -----
// ----------------------------------------------------------------------------
// ordered_route_table_unit: ordered IPv4 route table with first-match lookup
// Each request word on req (add, delete or lookup) gives one response word on
// rsp. Add appends a route, or answers bad prefix (prefix bits outside the
// mask, port out of range) or table full when all TABLE_DEPTH entries are in
// use. Delete removes every route whose prefix, mask, gateway and port match,
// packs the rest down in order and answers ok if anything was removed, else
// not found. Lookup answers with the first route in table order whose masked
// destination equals the prefix; the next hop is the gateway, or the
// destination itself for a directly connected route.
// The routes live in one memory with a single read port, so a lookup or
// delete reads one route per cycle, in table order, and then loads the
// output register. A lookup stops at its first hit. An add checks and
// writes its route in state S_ADD; an unused code goes straight to S_DONE.
// One request is worked on at a time; the next word is taken the cycle after
// the output register is loaded.
// Reset empties the table at once and drops any response not yet taken. A
// stalled receiver holds the response in the output register; the unit
// finishes the next request and then waits for it.
// ----------------------------------------------------------------------------
module ordered_route_table_unit #(
	parameter int unsigned TABLE_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	ort_req_if.sink     req,
	ort_rsp_if.source   rsp
);

	localparam int unsigned IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_ADD,
		S_SCAN,
		S_DONE
	} state_t;

	state_t          state_q;
	ort_pkg::req_t   req_q;
	logic [CntW-1:0] count_q;
	logic [CntW-1:0] rd_q;
	logic [CntW-1:0] wr_q;
	logic            pend_s1;
	logic            removed_q;
	ort_pkg::rsp_t   res_q;
	ort_pkg::rsp_t   out_q;
	logic            out_valid_q;

	ort_pkg::entry_t entry;
	ort_pkg::entry_t new_entry;
	ort_pkg::entry_t mem_wdata;
	logic [IdxW-1:0] mem_waddr;
	logic            mem_we;
	logic            issue;
	logic            lk_hit;
	logic            del_match;
	logic            del_keep;
	logic            scan_end;
	logic            add_bad;
	logic            add_full;
	logic            add_ok;
	logic            load_out;
	logic            accept;

	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;
	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_q;

	assign new_entry = '{prefix:  req_q.prefix_addr,
			     mask:    req_q.mask,
			     gateway: req_q.gateway,
			     port:    req_q.port,
			     source:  req_q.source_addr};

	// The scan reads one route per cycle; its data is judged in the next cycle.
	assign issue = (state_q == S_SCAN) && (rd_q != count_q);

	assign lk_hit = pend_s1 && (req_q.op == ort_pkg::OpLookup) &&
			((req_q.dest_addr & entry.mask) == entry.prefix);
	assign del_match = (entry.prefix == req_q.prefix_addr) &&
			   (entry.mask == req_q.mask) &&
			   (entry.gateway == req_q.gateway) &&
			   (entry.port == req_q.port);
	assign del_keep = pend_s1 && (req_q.op == ort_pkg::OpDel) && !del_match;
	assign scan_end = !pend_s1 && (rd_q == count_q);

	assign add_bad  = ((req_q.prefix_addr & ~req_q.mask) != 32'd0) ||
			  (32'(req_q.port) >= ort_pkg::PortCount);
	assign add_full = (count_q == CntW'(TABLE_DEPTH));
	assign add_ok   = !add_bad && !add_full;

	// A kept route is written back at the packing index, which never passes
	// the index being read, so a write never meets a pending read.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = wr_q[IdxW-1:0];
		mem_wdata = entry;
		if (state_q == S_ADD) begin
			mem_we    = add_ok;
			mem_waddr = count_q[IdxW-1:0];
			mem_wdata = new_entry;
		end else if (state_q == S_SCAN) begin
			mem_we = del_keep;
		end
	end

	assign load_out = (state_q == S_DONE) && (!out_valid_q || rsp.ready);

	ort_mem #(
		.DEPTH (TABLE_DEPTH),
		.AW    (IdxW)
	) u_mem (
		.clk     (clk),
		.wr_en   (mem_we),
		.wr_addr (mem_waddr),
		.wr_data (mem_wdata),
		.rd_en   (issue),
		.rd_addr (rd_q[IdxW-1:0]),
		.rd_data (entry)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			req_q       <= '0;
			count_q     <= '0;
			rd_q        <= '0;
			wr_q        <= '0;
			pend_s1     <= 1'b0;
			removed_q   <= 1'b0;
			res_q       <= '0;
			out_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// A new response replaces one being taken; otherwise a taken one drops.
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						req_q     <= req.data;
						rd_q      <= '0;
						wr_q      <= '0;
						pend_s1   <= 1'b0;
						removed_q <= 1'b0;
						unique case (req.data.op) inside
							ort_pkg::OpAdd: begin
								state_q <= S_ADD;
							end
							ort_pkg::OpDel, ort_pkg::OpLookup: begin
								state_q <= S_SCAN;
							end
							default: begin
								res_q   <= '{status: ort_pkg::StNotFound,
									     default: '0};
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_ADD: begin
					res_q <= '{status: add_bad ? ort_pkg::StBadPrefix :
							   add_full ? ort_pkg::StFull :
							   ort_pkg::StOk,
						   default: '0};
					if (add_ok) begin
						count_q <= count_q + CntW'(1);
					end
					state_q <= S_DONE;
				end
				S_SCAN: begin
					if (issue) begin
						rd_q <= rd_q + CntW'(1);
					end
					pend_s1 <= issue && !lk_hit;
					if (del_keep) begin
						wr_q <= wr_q + CntW'(1);
					end
					if (pend_s1 && (req_q.op == ort_pkg::OpDel) && del_match) begin
						removed_q <= 1'b1;
					end
					if (lk_hit) begin
						res_q <= '{status:     ort_pkg::StOk,
							   next_hop:   (entry.gateway != 32'd0) ?
								       entry.gateway : req_q.dest_addr,
							   out_port:   entry.port,
							   out_source: entry.source};
						state_q <= S_DONE;
					end else if (scan_end) begin
						if (req_q.op == ort_pkg::OpDel) begin
							count_q <= wr_q;
							res_q   <= '{status: removed_q ? ort_pkg::StOk :
									 ort_pkg::StNotFound,
								     default: '0};
						end else begin
							res_q <= '{status: ort_pkg::StNotFound,
								   default: '0};
						end
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (load_out) begin
						out_q   <= res_q;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// The route count never exceeds the table size.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CntW'(TABLE_DEPTH))
		else $error("route count exceeds table size");

	// Packing writes always land below the read index of the scan.
	a_pack_below_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN && mem_we) |-> (wr_q < rd_q))
		else $error("packing write overtakes the scan");

	// A successful add grows the table by exactly one route.
	a_add_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ADD && add_ok) |=> (count_q == $past(count_q) + CntW'(1)))
		else $error("add did not grow the table by one");

	// A delete never grows the table.
	a_del_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN && req_q.op == ort_pkg::OpDel) |=>
		(count_q <= $past(count_q)))
		else $error("delete grew the table");

	// No read is in flight when a new request is taken.
	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> !pend_s1)
		else $error("request accepted with a read in flight");

endmodule
